// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/swtb_pkg.sv -----
package swtb_pkg;

    // Field widths
    localparam int OP_W      = 3;
    localparam int SLOT_W    = 4;
    localparam int TICK_W    = 32;
    localparam int ELAPSED_W = 16;
    localparam int DIV_W     = 16;
    localparam int PROD_W    = 40;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 1;

    // Scale from ticks to tenths, and the divisor after reset
    localparam logic [PROD_W-1:0] TENTHS_SCALE  = 40'd100;
    localparam logic [DIV_W-1:0]  DIVISOR_RESET = 16'd182;

    typedef enum logic [OP_W-1:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_READ  = 3'd2,
        OP_RESET = 3'd3,
        OP_ZERO  = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVISOR = 1'b0,
        CFG_ENABLE  = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_RUN
    } div_state_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// ----- sv/swtb_ifs.sv -----
// Command request channel
interface swtb_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [swtb_pkg::OP_W-1:0]    op;
    logic [swtb_pkg::SLOT_W-1:0]  slot;
    logic [swtb_pkg::TICK_W-1:0]  now;

    modport source (output valid, output op, output slot, output now, input ready);
    modport sink   (input valid, input op, input slot, input now, output ready);
endinterface

// Result request channel
interface swtb_res_if;
    logic                           valid;
    logic                           ready;
    logic [swtb_pkg::ELAPSED_W-1:0] elapsed;
    logic                           took_effect;

    modport source (output valid, output elapsed, output took_effect, input ready);
    modport sink   (input valid, input elapsed, input took_effect, output ready);
endinterface

// Register write channel
interface swtb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [swtb_pkg::CFG_IDX_W-1:0] index;
    logic [swtb_pkg::DIV_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/swtb_div.sv -----
`include "assert_macros.svh"

module swtb_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swtb_pkg::div_ctl_t            ctl,
    input  logic [swtb_pkg::TICK_W-1:0]   ticks,
    input  logic [swtb_pkg::DIV_W-1:0]    divisor,
    output swtb_pkg::div_sts_t            sts,
    output logic [swtb_pkg::ELAPSED_W-1:0] quotient
);
    import swtb_pkg::*;

    div_state_t            dstate_reg, dstate_next;
    logic [TICK_W-1:0]     ticks_reg, ticks_next;
    logic [PROD_W-1:0]     dvd_reg, dvd_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [ELAPSED_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;

    logic [DIV_W:0]        trial;
    logic [DIV_W:0]        trial_sub;
    logic                  fits;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[PROD_W-1]};
        trial_sub = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
    end

    // Next state
    always_comb
    begin
        dstate_next = dstate_reg;
        case (dstate_reg)
            D_IDLE:  if (ctl.start) dstate_next = D_MUL;
            D_MUL:   dstate_next = D_RUN;
            D_RUN:   if (cnt_reg == '0) dstate_next = D_IDLE;
            default: dstate_next = D_IDLE;
        endcase
    end

    // Datapath updates
    always_comb
    begin
        ticks_next = ticks_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (dstate_reg)
            D_IDLE:
            begin
                if (ctl.start)
                    ticks_next = ticks;
            end
            D_MUL:
            begin
                // Scale to tenths; the product fits in 40 bits
                dvd_next = PROD_W'({{(PROD_W-TICK_W){1'b0}}, ticks_reg} * TENTHS_SCALE);
                rem_next = '0;
                cnt_next = CNT_W'(PROD_W - 1);
            end
            D_RUN:
            begin
                dvd_next = {dvd_reg[PROD_W-2:0], 1'b0};
                rem_next = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
                quo_next = {quo_reg[ELAPSED_W-2:0], fits};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= D_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            dstate_reg <= dstate_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ticks_reg <= ticks_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    // Outputs
    always_comb
    begin
        sts.busy = (dstate_reg != D_IDLE);
        sts.done = done_reg;
        quotient = quo_reg;
    end

    `ASSERT_IMPLIES(a_start_when_free, clk, rst_n, ctl.start, dstate_reg == D_IDLE)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `ASSERT_IMPLIES(a_cnt_range, clk, rst_n, dstate_reg == D_RUN, cnt_reg <= CNT_W'(PROD_W - 1))

endmodule

// ----- sv/stopwatch_timer_bank_unit.sv -----
// Stopwatch bank: each command names a slot and carries the current 32-bit tick
// count. Start (only while enabled, on an idle slot) latches the count, zero
// relatches a running slot, stop and read return (now - start) * 100 / divisor
// truncated to 16 bits, and stop and reset idle the slot. One command is worked
// on at a time. A command is taken in the idle step and looked up in the lookup
// step; its result is loaded into the output register in the done step, and the
// block then returns to idle to take the next command. Stop and read on a running
// slot wait between lookup and done for the bit-serial divider, which retires one
// of the 40 product bits per cycle. A result that waits for res.ready holds the
// block in its last step only until the output register frees; the next command
// is taken while a finished result still waits there. Nothing needs clearing
// after reset, and register writes are taken at any time through a port that is
// always ready.
`include "assert_macros.svh"

module stopwatch_timer_bank_unit #(
    parameter int NUM_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    swtb_cmd_if.sink    cmd,
    swtb_res_if.source  res,
    swtb_cfg_if.sink    cfg
);
    import swtb_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CMP_W = 7;

    state_t                state_reg, state_next;
    op_t                   op_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  hit_reg;
    logic [TICK_W-1:0]     now_reg;
    logic [TICK_W-1:0]     rd_data_reg;
    logic [NUM_SLOTS-1:0]  running_reg, running_next;
    logic                  took_reg, took_next;
    logic                  div_used_reg, div_used_next;
    logic [DIV_W-1:0]      divisor_reg, divisor_next;
    logic                  enable_reg, enable_next;
    logic                  res_valid_reg, res_valid_next;
    logic [ELAPSED_W-1:0]  res_elapsed_reg, res_elapsed_next;
    logic                  res_took_reg, res_took_next;

    logic [TICK_W-1:0]     start_mem [NUM_SLOTS];

    logic                  cmd_acc;
    logic                  cfg_acc;
    logic                  out_free;
    logic [CMP_W-1:0]      slot_ext;
    logic [IDX_W-1:0]      idx_in;
    logic                  hit_in;
    logic                  on;
    logic                  eff;
    logic                  need_div;
    logic                  mem_we;
    div_ctl_t              div_ctl;
    div_sts_t              div_sts;
    logic [ELAPSED_W-1:0]  div_quo;
    logic [TICK_W-1:0]     tick_diff;

    // Handshakes and slot decode
    always_comb
    begin
        cmd_acc  = cmd.valid && cmd.ready;
        cfg_acc  = cfg.valid && cfg.ready;
        out_free = !res_valid_reg || res.ready;
        slot_ext = {{(CMP_W-SLOT_W){1'b0}}, cmd.slot};
        idx_in   = slot_ext[IDX_W-1:0];
        hit_in   = (slot_ext < CMP_W'(NUM_SLOTS));
    end

    // Decide what the command does to its slot
    always_comb
    begin
        on        = hit_reg && running_reg[idx_reg];
        eff       = 1'b0;
        need_div  = 1'b0;
        mem_we    = 1'b0;
        tick_diff = now_reg - rd_data_reg;
        case (op_reg)
            OP_START:
            begin
                eff    = hit_reg && enable_reg && !on;
                mem_we = eff;
            end
            OP_STOP, OP_READ:
            begin
                eff      = on;
                need_div = on;
            end
            OP_RESET:
            begin
                eff = on;
            end
            OP_ZERO:
            begin
                eff    = on;
                mem_we = on;
            end
            default:
            begin
                eff = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (cmd_acc) state_next = S_LOOK;
            S_LOOK:  state_next = need_div ? S_WAIT : S_DONE;
            S_WAIT:  if (div_sts.done) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        cmd.ready     = (state_reg == S_IDLE);
        cfg.ready     = 1'b1;
        div_ctl.start = (state_reg == S_LOOK) && need_div;
    end

    // Slot state, register file and result staging
    always_comb
    begin
        running_next     = running_reg;
        took_next        = took_reg;
        div_used_next    = div_used_reg;
        divisor_next     = divisor_reg;
        enable_next      = enable_reg;
        res_valid_next   = res_valid_reg;
        res_elapsed_next = res_elapsed_reg;
        res_took_next    = res_took_reg;

        if (state_reg == S_LOOK)
        begin
            took_next     = eff;
            div_used_next = need_div;
            if (eff && op_reg == OP_START)
                running_next[idx_reg] = 1'b1;
            if (eff && (op_reg == OP_STOP || op_reg == OP_RESET))
                running_next[idx_reg] = 1'b0;
        end

        // Drop the delivered result, then load a finished one
        if (res_valid_reg && res.ready)
            res_valid_next = 1'b0;
        if (state_reg == S_DONE && out_free)
        begin
            res_valid_next   = 1'b1;
            res_elapsed_next = div_used_reg ? div_quo : '0;
            res_took_next    = took_reg;
        end

        if (cfg_acc)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_DIVISOR: divisor_next = cfg.data;
                CFG_ENABLE:  enable_next  = cfg.data[0];
                default:     enable_next  = enable_reg;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            running_reg   <= '0;
            took_reg      <= 1'b0;
            div_used_reg  <= 1'b0;
            divisor_reg   <= DIVISOR_RESET;
            enable_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            took_reg      <= took_next;
            div_used_reg  <= div_used_next;
            divisor_reg   <= divisor_next;
            enable_reg    <= enable_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold the command fields and the result payload
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            op_reg  <= op_t'(cmd.op);
            idx_reg <= idx_in;
            hit_reg <= hit_in;
            now_reg <= cmd.now;
        end
        res_elapsed_reg <= res_elapsed_next;
        res_took_reg    <= res_took_next;
    end

    // Start-count memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOOK && mem_we)
            start_mem[idx_reg] <= now_reg;
        if (cmd_acc)
            rd_data_reg <= start_mem[idx_in];
    end

    swtb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .ticks    (tick_diff),
        .divisor  (divisor_reg),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    always_comb
    begin
        res.valid       = res_valid_reg;
        res.elapsed     = res_elapsed_reg;
        res.took_effect = res_took_reg;
    end

    `ASSERT_NEXT(a_accept_to_look, clk, rst_n, cmd_acc, state_reg == S_LOOK)
    `ASSERT_IMPLIES(a_elapsed_needs_effect, clk, rst_n, res_valid_reg && res_elapsed_reg != '0, res_took_reg)
    `ASSERT_IMPLIES(a_wait_means_busy, clk, rst_n, state_reg == S_WAIT && !div_sts.done, div_sts.busy)

endmodule

// ----- tb/stopwatch_timer_bank_unit_test.sv -----
module stopwatch_timer_bank_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swtb_pkg::*;

    localparam int NUM_SLOTS      = 16;
    localparam int IDLE_PCT       = 29;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 125;
    localparam int QUIET_PHASE    = 6;
    localparam int DISABLED_PHASE = 5;

    // Command codes with no meaning; the block must ignore them
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    localparam logic [ELAPSED_W-1:0] ELAPSED_SATURATED = '1;
    localparam logic [PROD_W-1:0]    TICK_SCALE        = 40'd100;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        logic                 took_effect;
    } timing_result_t;

    logic clk = 1'b0;
    logic rst_n;

    swtb_cmd_if cmd_if();
    swtb_res_if res_if();
    swtb_cfg_if cfg_if();

    // Shadow copy of the bank and its registers
    logic [DIV_W-1:0]  divisor_q;
    logic              enable_q;
    logic [TICK_W-1:0] latched_tick [NUM_SLOTS];
    logic              slot_running [NUM_SLOTS];

    timing_result_t    pending_results [$];
    int                error_count = 0;
    logic              no_gaps = 1'b0;
    logic [TICK_W-1:0] tick_clock = '0;

    stopwatch_timer_bank_unit #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    always #5 clk = ~clk;

    // Elapsed tenths: wrapped 32-bit tick difference, scaled, divided, truncated
    function automatic logic [ELAPSED_W-1:0] tenths_between(
        logic [TICK_W-1:0] begin_tick,
        logic [TICK_W-1:0] now_tick
    );
        logic [TICK_W-1:0] ticks;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quot;
        ticks = now_tick - begin_tick;
        prod  = {{(PROD_W-TICK_W){1'b0}}, ticks} * TICK_SCALE;
        if (divisor_q == '0)
            return ELAPSED_SATURATED;
        quot = prod / {{(PROD_W-DIV_W){1'b0}}, divisor_q};
        return quot[ELAPSED_W-1:0];
    endfunction

    // Apply one command to the shadow bank and return what the block must answer
    function automatic timing_result_t predict_command(
        logic [OP_W-1:0]   op,
        logic [SLOT_W-1:0] slot,
        logic [TICK_W-1:0] now_tick
    );
        timing_result_t r;
        logic           on;
        r  = '0;
        on = slot_running[slot];
        case (op)
            OP_START:
                if (enable_q && !on)
                begin
                    latched_tick[slot] = now_tick;
                    slot_running[slot] = 1'b1;
                    r.took_effect      = 1'b1;
                end
            OP_STOP:
                if (on)
                begin
                    r.elapsed          = tenths_between(latched_tick[slot], now_tick);
                    slot_running[slot] = 1'b0;
                    latched_tick[slot] = '0;
                    r.took_effect      = 1'b1;
                end
            OP_READ:
                if (on)
                begin
                    r.elapsed     = tenths_between(latched_tick[slot], now_tick);
                    r.took_effect = 1'b1;
                end
            OP_RESET:
                if (on)
                begin
                    slot_running[slot] = 1'b0;
                    latched_tick[slot] = '0;
                    r.took_effect      = 1'b1;
                end
            OP_ZERO:
                if (on)
                begin
                    latched_tick[slot] = now_tick;
                    r.took_effect      = 1'b1;
                end
            default: ;
        endcase
        return r;
    endfunction

    // Send one command request, with random idle cycles ahead of it
    task automatic send_cmd(
        logic [OP_W-1:0]   op,
        logic [SLOT_W-1:0] slot,
        logic [TICK_W-1:0] now_tick
    );
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.op    <= op;
        cmd_if.slot  <= slot;
        cmd_if.now   <= now_tick;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        pending_results.push_back(predict_command(op, slot, now_tick));
    endtask

    // Write one register once the bank has answered every command
    task automatic write_reg(cfg_idx_t idx, logic [DIV_W-1:0] data);
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_DIVISOR)
            divisor_q = data;
        else
            enable_q = data[0];
    endtask

    // Disabled bank after reset: nothing starts, idle slots and unused codes answer zero
    task automatic test_reset_state();
        send_cmd(OP_START, 4'd0, 32'd10);
        send_cmd(OP_READ, 4'd0, 32'd20);
        send_cmd(OP_STOP, 4'd1, 32'hFFFF_FFFF);
        send_cmd(OP_RESET, 4'd2, 32'd0);
        send_cmd(OP_ZERO, 4'd3, 32'h8000_0000);
        send_cmd(OP_UNUSED_FIRST, 4'd15, 32'h5555_5555);
        send_cmd(OP_UNUSED_MID, 4'd15, 32'hAAAA_AAAA);
        send_cmd(OP_UNUSED_LAST, 4'd15, 32'hFFFF_FFFF);
    endtask

    // Default divisor: start, restart refused, zero, counter wrap, stop and reset
    task automatic test_default_divisor();
        write_reg(CFG_ENABLE, 16'd1);
        send_cmd(OP_START, 4'd0, 32'd0);
        send_cmd(OP_READ, 4'd0, 32'd182);
        send_cmd(OP_START, 4'd0, 32'd500);
        send_cmd(OP_ZERO, 4'd0, 32'd1000);
        send_cmd(OP_READ, 4'd0, 32'd2820);
        send_cmd(OP_START, 4'd15, 32'hFFFF_FFF0);
        send_cmd(OP_READ, 4'd15, 32'h0000_0010);
        send_cmd(OP_STOP, 4'd15, 32'hFFFF_FFFF);
        send_cmd(OP_RESET, 4'd0, 32'd3000);
        send_cmd(OP_READ, 4'd0, 32'd4000);
    endtask

    // Divisor extremes, including divide by zero on a running slot
    task automatic test_divisor_extremes();
        write_reg(CFG_DIVISOR, 16'd1);
        send_cmd(OP_START, 4'd7, 32'd0);
        send_cmd(OP_READ, 4'd7, 32'hFFFF_FFFF);
        send_cmd(OP_STOP, 4'd7, 32'd655);
        write_reg(CFG_DIVISOR, 16'hFFFF);
        send_cmd(OP_START, 4'd8, 32'h1234_5678);
        send_cmd(OP_READ, 4'd8, 32'h1234_5677);
        write_reg(CFG_DIVISOR, 16'd0);
        send_cmd(OP_READ, 4'd8, 32'h2000_0000);
        send_cmd(OP_STOP, 4'd8, 32'h2000_0001);
    endtask

    // Random traffic over several register settings; mostly well-formed per slot
    task automatic test_random_traffic();
        logic [DIV_W-1:0]  div_val;
        logic [DIV_W-1:0]  en_val;
        logic [SLOT_W-1:0] slot;
        logic [OP_W-1:0]   op;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       div_val = DIVISOR_RESET;
                1:       div_val = 16'd1;
                2:       div_val = 16'hFFFF;
                3:       div_val = 16'd0;
                4:       div_val = 16'($urandom_range(1, 16));
                default: div_val = 16'($urandom_range(1, 65535));
            endcase
            en_val    = 16'($urandom);
            en_val[0] = (phase != DISABLED_PHASE);
            write_reg(CFG_DIVISOR, div_val);
            write_reg(CFG_ENABLE, en_val);
            no_gaps = (phase == QUIET_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Advance the tick counter, with an occasional jump anywhere
                if ($urandom_range(0, 15) == 0)
                    tick_clock = $urandom;
                else
                    tick_clock = tick_clock + $urandom_range(0, 3000);
                slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
                if ($urandom_range(0, 99) < 80)
                begin
                    if (!slot_running[slot])
                        op = OP_START;
                    else
                        case ($urandom_range(0, 7))
                            0, 1, 2, 3: op = OP_READ;
                            4:          op = OP_ZERO;
                            5, 6:       op = OP_STOP;
                            default:    op = OP_RESET;
                        endcase
                end
                else
                begin
                    op = OP_W'($urandom_range(0, 7));
                end
                send_cmd(op, slot, tick_clock);
            end
        end
        no_gaps = 1'b0;
    endtask

    // Compare each result with the oldest prediction; drive result ready
    always @(posedge clk)
    begin
        timing_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected result: expected none, actual elapsed %0d took %0d",
                         $time, res_if.elapsed, res_if.took_effect);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_if.elapsed !== want.elapsed)
                begin
                    error_count++;
                    $display("%0t elapsed mismatch: expected %0d actual %0d",
                             $time, want.elapsed, res_if.elapsed);
                end
                if (res_if.took_effect !== want.took_effect)
                begin
                    error_count++;
                    $display("%0t took_effect mismatch: expected %0d actual %0d",
                             $time, want.took_effect, res_if.took_effect);
                end
            end
        end
        res_if.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial
    begin
        rst_n        = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.op    = OP_START;
        cmd_if.slot  = '0;
        cmd_if.now   = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_DIVISOR;
        cfg_if.data  = '0;
        divisor_q    = DIVISOR_RESET;
        enable_q     = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            latched_tick[i] = '0;
            slot_running[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_default_divisor();
        test_divisor_extremes();
        test_random_traffic();

        // Drop the command request and let the last results drain
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/swtb_pkg.sv
sv/swtb_ifs.sv
sv/swtb_div.sv
sv/stopwatch_timer_bank_unit.sv
tb/stopwatch_timer_bank_unit_test.sv
